### rtl/mexp_pkg.sv
// mexp_pkg: widths, codes and the control program of the modular exponentiation unit.
// Used by mexp_modred and modular_exponentiation_unit; depends on nothing.
package mexp_pkg;

	localparam int EXP_BITS  = 32;                  // exponent bits scanned from bit 0
	localparam int MOD_W     = 31;                  // modulus, base, residue, exponent width
	localparam int PROD_W    = 2 * MOD_W;           // full product width
	localparam int RCNT_W    = $clog2(PROD_W + 1);  // reduction bit counter
	localparam int ECNT_W    = $clog2(EXP_BITS + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int PC_W      = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd1;

	// multiplier operand selects
	localparam logic [1:0] SEL_A_ONE  = 2'd0;
	localparam logic [1:0] SEL_A_BASE = 2'd1;
	localparam logic [1:0] SEL_A_ACC  = 2'd2;
	localparam logic [1:0] SEL_A_SQ   = 2'd3;
	localparam logic       SEL_B_ONE  = 1'b0;
	localparam logic       SEL_B_SQ   = 1'b1;

	// jump conditions: taken -> target, else pc + 1
	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NOIN    = 3'd2;  // no input item offered
	localparam logic [2:0] C_BUSY    = 3'd3;  // reduction still running
	localparam logic [2:0] C_BIT0    = 3'd4;  // current exponent bit is zero
	localparam logic [2:0] C_MORE    = 3'd5;  // exponent bits left to scan
	localparam logic [2:0] C_OUTFULL = 3'd6;  // result register held by a stall

	typedef struct packed {
		logic [1:0]      sel_a;
		logic            sel_b;
		logic            mul;      // register a*b
		logic            red;      // start reduction of the product
		logic            wr_sq;    // square register <- remainder
		logic            wr_acc;   // result accumulator <- remainder
		logic            step;     // next exponent bit
		logic            out_ld;   // load result register
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} uc_word_t;

	// program addresses
	localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
	localparam logic [PC_W-1:0] PC_B_MUL    = 5'd1;
	localparam logic [PC_W-1:0] PC_B_RED    = 5'd2;
	localparam logic [PC_W-1:0] PC_B_WAIT   = 5'd3;
	localparam logic [PC_W-1:0] PC_B_WR     = 5'd4;
	localparam logic [PC_W-1:0] PC_O_MUL    = 5'd5;
	localparam logic [PC_W-1:0] PC_O_RED    = 5'd6;
	localparam logic [PC_W-1:0] PC_O_WAIT   = 5'd7;
	localparam logic [PC_W-1:0] PC_O_WR     = 5'd8;
	localparam logic [PC_W-1:0] PC_LOOP     = 5'd9;
	localparam logic [PC_W-1:0] PC_M_MUL    = 5'd10;
	localparam logic [PC_W-1:0] PC_M_RED    = 5'd11;
	localparam logic [PC_W-1:0] PC_M_WAIT   = 5'd12;
	localparam logic [PC_W-1:0] PC_M_WR     = 5'd13;
	localparam logic [PC_W-1:0] PC_S_MUL    = 5'd14;
	localparam logic [PC_W-1:0] PC_S_RED    = 5'd15;
	localparam logic [PC_W-1:0] PC_S_WAIT   = 5'd16;
	localparam logic [PC_W-1:0] PC_S_WR     = 5'd17;
	localparam logic [PC_W-1:0] PC_NEXT     = 5'd18;
	localparam logic [PC_W-1:0] PC_OUT_WAIT = 5'd19;
	localparam logic [PC_W-1:0] PC_OUT_LD   = 5'd20;

	// flags, msb first: mul, red, wr_sq, wr_acc, step, out_ld
	function automatic uc_word_t uc(input logic [1:0] sel_a, input logic sel_b,
			input logic [5:0] flags, input logic [2:0] cond,
			input logic [PC_W-1:0] target);
		uc_word_t w;
		w.sel_a  = sel_a;
		w.sel_b  = sel_b;
		{w.mul, w.red, w.wr_sq, w.wr_acc, w.step, w.out_ld} = flags;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
		uc_word_t w;
		case (pc)
			// wait for an exponent
			PC_IDLE:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_NOIN,    PC_IDLE);
			// sq = base mod m
			PC_B_MUL:    w = uc(SEL_A_BASE, SEL_B_ONE, 6'b100000, C_NEVER,   PC_IDLE);
			PC_B_RED:    w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b010000, C_NEVER,   PC_IDLE);
			PC_B_WAIT:   w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_BUSY,    PC_B_WAIT);
			PC_B_WR:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b001000, C_NEVER,   PC_IDLE);
			// acc = 1 mod m
			PC_O_MUL:    w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b100000, C_NEVER,   PC_IDLE);
			PC_O_RED:    w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b010000, C_NEVER,   PC_IDLE);
			PC_O_WAIT:   w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_BUSY,    PC_O_WAIT);
			PC_O_WR:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000100, C_NEVER,   PC_IDLE);
			// per exponent bit: acc = acc*sq if bit set
			PC_LOOP:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_BIT0,    PC_S_MUL);
			PC_M_MUL:    w = uc(SEL_A_ACC,  SEL_B_SQ,  6'b100000, C_NEVER,   PC_IDLE);
			PC_M_RED:    w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b010000, C_NEVER,   PC_IDLE);
			PC_M_WAIT:   w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_BUSY,    PC_M_WAIT);
			PC_M_WR:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000100, C_NEVER,   PC_IDLE);
			// sq = sq*sq, then advance to next bit
			PC_S_MUL:    w = uc(SEL_A_SQ,   SEL_B_SQ,  6'b100000, C_NEVER,   PC_IDLE);
			PC_S_RED:    w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b010000, C_NEVER,   PC_IDLE);
			PC_S_WAIT:   w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_BUSY,    PC_S_WAIT);
			PC_S_WR:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b001010, C_NEVER,   PC_IDLE);
			PC_NEXT:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_MORE,    PC_LOOP);
			// hand the residue over
			PC_OUT_WAIT: w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_OUTFULL, PC_OUT_WAIT);
			PC_OUT_LD:   w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000001, C_ALWAYS,  PC_IDLE);
			default:     w = uc(SEL_A_ONE,  SEL_B_ONE, 6'b000000, C_ALWAYS,  PC_IDLE);
		endcase
		return w;
	endfunction

endpackage

### rtl/modular_exponentiation_unit.sv
// modular_exponentiation_unit: base^exponent mod modulus by square-and-multiply.
// Depends on mexp_pkg and mexp_modred.
//
//   channel   signals                                  direction  transfer when
//   input     in_valid, in_stall, exponent             in         in_valid & !in_stall
//   output    out_valid, out_stall, residue            out        out_valid & !out_stall
//   config    cfg_valid, cfg_ready, cfg_index,         in         cfg_valid & cfg_ready
//             cfg_data
//
// One exponent at a time. Every modular product is a 31x31 multiply into a
// product register followed by a bit-serial reduction of the 62-bit product;
// an item's run time grows with EXP_BITS and with the exponent's one bits and
// is set by the serial reduction unit.
// Reset clears the sequencer, the result register's valid and the registers
// (modulus 1, base 0). A stalled result sits in its own register while the
// next exponent is taken and worked on; only the final load waits for it.
// cfg_ready is always high; writes are expected only while the unit is idle.
module modular_exponentiation_unit
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// exponent channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MOD_W-1:0]     exponent,
	// residue channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MOD_W-1:0]     residue,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// configuration
	logic [MOD_W-1:0]  modulus_q;
	logic [MOD_W-1:0]  base_q;
	logic [MOD_W-1:0]  mod_eff;

	// sequencer
	logic [PC_W-1:0]   pc_q;
	uc_word_t          uw;
	logic              jump;

	// datapath
	logic [MOD_W-1:0]  exp_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic [MOD_W-1:0]  sq_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  op_a;
	logic [MOD_W-1:0]  op_b;
	logic [PROD_W-1:0] prod_q;
	logic              red_busy;
	logic [MOD_W-1:0]  red_rem;

	// result register
	logic              out_valid_q;
	logic [MOD_W-1:0]  residue_q;

	logic              in_xfer;
	logic              out_xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_W'(1);
			base_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data[MOD_W-1:0];
				REG_BASE:    base_q    <= cfg_data[MOD_W-1:0];
				default:     ;
			endcase
		end
	end

	// modulus zero behaves as modulus one
	assign mod_eff = (modulus_q == '0) ? MOD_W'(1) : modulus_q;

	// --- sequencer: fetch, condition test, next address ---
	assign uw = uc_rom(pc_q);

	always_comb begin
		case (uw.cond)
			C_NEVER:   jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NOIN:    jump = !in_valid;
			C_BUSY:    jump = red_busy;
			C_BIT0:    jump = !exp_q[0];
			C_MORE:    jump = (ecnt_q != ECNT_W'(EXP_BITS));
			C_OUTFULL: jump = out_valid_q && out_stall;
			default:   jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 1'b1;
		end
	end

	// exponent is taken only in the idle step
	assign in_stall = (pc_q != PC_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			exp_q  <= exponent;
			ecnt_q <= '0;
		end else if (uw.step) begin
			exp_q  <= {1'b0, exp_q[MOD_W-1:1]};
			ecnt_q <= ecnt_q + 1'b1;
		end
	end

	// --- multiplier, registered ---
	always_comb begin
		case (uw.sel_a)
			SEL_A_ONE:  op_a = MOD_W'(1);
			SEL_A_BASE: op_a = base_q;
			SEL_A_ACC:  op_a = acc_q;
			SEL_A_SQ:   op_a = sq_q;
			default:    op_a = MOD_W'(1);
		endcase
		op_b = (uw.sel_b == SEL_B_SQ) ? sq_q : MOD_W'(1);
	end

	always_ff @(posedge clk) begin
		if (uw.mul) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	// --- serial reduction ---
	mexp_modred u_modred (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (uw.red),
		.prod    (prod_q),
		.modulus (mod_eff),
		.busy    (red_busy),
		.rem     (red_rem)
	);

	always_ff @(posedge clk) begin
		if (uw.wr_sq) begin
			sq_q <= red_rem;
		end
		if (uw.wr_acc) begin
			acc_q <= red_rem;
		end
	end

	// --- result register ---
	assign out_xfer = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.out_ld) begin
			residue_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign residue   = residue_q;

endmodule

### rtl/mexp_modred.sv
// mexp_modred: bit-serial restoring reduction of a full-width product modulo m.
// Depends on mexp_pkg.
module mexp_modred
	import mexp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] prod,
	input  logic [MOD_W-1:0]  modulus,  // nonzero
	output logic              busy,
	output logic [MOD_W-1:0]  rem
);

	logic [MOD_W-1:0]  rem_q;
	logic [PROD_W-1:0] shift_q;
	logic [RCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [MOD_W:0]    trial;
	logic [MOD_W:0]    diff;

	// one product bit per cycle, msb first
	assign trial = {rem_q, shift_q[PROD_W-1]};
	assign diff  = trial - {1'b0, modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= RCNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == RCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= prod;
		end else if (busy_q) begin
			shift_q <= {shift_q[PROD_W-2:0], 1'b0};
			if (trial >= {1'b0, modulus}) begin
				rem_q <= diff[MOD_W-1:0];
			end else begin
				rem_q <= trial[MOD_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule
